// File: src/m4rm_pkg.sv
`default_nettype none

package m4rm_pkg;

   localparam int unsigned ELEM_W = 32;
   localparam int unsigned DIM    = 4;
   localparam int unsigned PROD_W = 2 * ELEM_W;
   localparam int unsigned SUM_W  = PROD_W + 2;
   localparam int unsigned FRAC_W = 16;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic [1:0]               row_type;

   // request function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_MUL  = 1'b1;

   // per-stage capture enables shared by all column lanes
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } adv_type;

endpackage : m4rm_pkg

`default_nettype wire

// File: src/m4rm_dot_lane.sv
`default_nettype none

module m4rm_dot_lane (
   input  wire logic               clock,
   input  wire m4rm_pkg::adv_type  adv,
   input  wire m4rm_pkg::elem_type a [4],
   input  wire m4rm_pkg::elem_type b [4],
   output      m4rm_pkg::elem_type prod,
   output      logic               sat
);
   import m4rm_pkg::*;

   logic signed [PROD_W-1:0]  mul_ff [DIM];
   logic signed [PROD_W:0]    pair_ff [2];
   logic signed [SUM_W-1:0]   sum_ff;
   elem_type                  prod_ff;
   logic                      sat_ff;

   logic signed [SUM_W-FRAC_W-1:0] shifted;
   logic                           over;
   elem_type                       clamp_in;

   // stage 1: four exact products
   always_ff @(posedge clock) begin
      if (adv.s1) begin
         for (int k = 0; k < DIM; k++) begin
            mul_ff[k] <= PROD_W'(a[k] * b[k]);
         end
      end
   end

   // stage 2: pairwise sums
   always_ff @(posedge clock) begin
      if (adv.s2) begin
         pair_ff[0] <= (PROD_W+1)'(mul_ff[0]) + (PROD_W+1)'(mul_ff[1]);
         pair_ff[1] <= (PROD_W+1)'(mul_ff[2]) + (PROD_W+1)'(mul_ff[3]);
      end
   end

   // stage 3: full-width sum
   always_ff @(posedge clock) begin
      if (adv.s3) begin
         sum_ff <= SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);
      end
   end

   // stage 4: floor shift and clamp to 32 bits
   always_comb begin
      shifted  = sum_ff[SUM_W-1:FRAC_W];
      over     = !((&shifted[SUM_W-FRAC_W-1:ELEM_W-1]) ||
                   !(|shifted[SUM_W-FRAC_W-1:ELEM_W-1]));
      if (!over) begin
         clamp_in = shifted[ELEM_W-1:0];
      end else if (shifted[SUM_W-FRAC_W-1]) begin
         clamp_in = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         clamp_in = {1'b0, {(ELEM_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         prod_ff <= clamp_in;
         sat_ff  <= over;
      end
   end

   assign prod = prod_ff;
   assign sat  = sat_ff;

endmodule : m4rm_dot_lane

`default_nettype wire

// File: src/mat4_row_multiply_top.sv
`default_nettype none

// Channel  Ports                                  Direction  Carries
// req      req_valid/req_ready, req_func,          in         load or multiply request
//          req_row_index, req_elem0..3
// rsp      rsp_valid/rsp_ready, rsp_out_row,       out        one result row per multiply
//          rsp_prod0..3, rsp_saturated
//
// A multiply request can enter every cycle unless a stalled output holds the pipeline; its result
// then passes the product, pair sum, full sum and shift/clamp stages into the output register.
// A load request writes its row into the right-hand store at acceptance and
// produces no result; a multiply accepted in the next cycle already sees it.
// Reset clears the store to zero and empties the pipeline.
// A stalled output holds the full stages that have no empty stage between them and it; the others still move on.

module mat4_row_multiply_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic               req_func,
   input  wire m4rm_pkg::row_type  req_row_index,
   input  wire m4rm_pkg::elem_type req_elem0,
   input  wire m4rm_pkg::elem_type req_elem1,
   input  wire m4rm_pkg::elem_type req_elem2,
   input  wire m4rm_pkg::elem_type req_elem3,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      m4rm_pkg::row_type  rsp_out_row,
   output      m4rm_pkg::elem_type rsp_prod0,
   output      m4rm_pkg::elem_type rsp_prod1,
   output      m4rm_pkg::elem_type rsp_prod2,
   output      m4rm_pkg::elem_type rsp_prod3,
   output      logic               rsp_saturated
);
   import m4rm_pkg::*;

   // right-hand matrix, entry {row, col}
   elem_type rmat_ff [DIM*DIM];

   logic     v1_ff, v2_ff, v3_ff, v4_ff;
   row_type  row1_ff, row2_ff, row3_ff, row4_ff;
   logic     rdy1, rdy2, rdy3, rdy4;
   logic     accept;
   adv_type  adv;

   elem_type a_row [DIM];
   elem_type b_col [DIM][DIM];
   elem_type prod [DIM];
   logic     sat [DIM];

   // a stage takes new data when it is empty or its contents move on
   assign rdy4   = !v4_ff || rsp_ready;
   assign rdy3   = !v3_ff || rdy4;
   assign rdy2   = !v2_ff || rdy3;
   assign rdy1   = !v1_ff || rdy2;
   assign accept = req_valid && rdy1;

   assign adv.s1 = rdy1;
   assign adv.s2 = rdy2;
   assign adv.s3 = rdy3;
   assign adv.s4 = rdy4;

   assign req_ready = rdy1;

   // write the loaded row at acceptance
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIM*DIM; i++) begin
            rmat_ff[i] <= '0;
         end
      end else if (accept && req_func == FUNC_LOAD) begin
         rmat_ff[{req_row_index, 2'd0}] <= req_elem0;
         rmat_ff[{req_row_index, 2'd1}] <= req_elem1;
         rmat_ff[{req_row_index, 2'd2}] <= req_elem2;
         rmat_ff[{req_row_index, 2'd3}] <= req_elem3;
      end
   end

   // advance valid bits alongside the lane data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= accept && req_func == FUNC_MUL;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) row1_ff <= req_row_index;
      if (rdy2) row2_ff <= row1_ff;
      if (rdy3) row3_ff <= row2_ff;
      if (rdy4) row4_ff <= row3_ff;
   end

   assign a_row[0] = req_elem0;
   assign a_row[1] = req_elem1;
   assign a_row[2] = req_elem2;
   assign a_row[3] = req_elem3;

   // one lane per result column; lane j reads column j of the store
   for (genvar j = 0; j < DIM; j++) begin : g_lane
      for (genvar k = 0; k < DIM; k++) begin : g_tap
         assign b_col[j][k] = rmat_ff[k*DIM + j];
      end

      m4rm_dot_lane u_lane (
         .clock (clock),
         .adv   (adv),
         .a     (a_row),
         .b     (b_col[j]),
         .prod  (prod[j]),
         .sat   (sat[j])
      );
   end

   assign rsp_valid     = v4_ff;
   assign rsp_out_row   = row4_ff;
   assign rsp_prod0     = prod[0];
   assign rsp_prod1     = prod[1];
   assign rsp_prod2     = prod[2];
   assign rsp_prod3     = prod[3];
   assign rsp_saturated = sat[0] || sat[1] || sat[2] || sat[3];

endmodule : mat4_row_multiply_top

`default_nettype wire
